// ===== rtl/mwrm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwrm_pkg
// Types and constants shared by the moving-window rms / mean block.
// ----------------------------------------------------------------------------
`default_nettype none

package mwrm_pkg;

    localparam int SAMPLE_W    = 16;            // input sample width
    localparam int LEN_W       = 11;            // window length register width
    localparam int SUM_W       = 42;            // signed running sum width
    localparam int DIV_W       = SUM_W - 1;     // magnitude of the running sum
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int ROOT_IN_W   = 32;            // square root radicand width
    localparam int ROOT_W      = ROOT_IN_W / 2;
    localparam int VALUE_W     = 17;            // result value width
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 1;
    localparam int CFG_ADDR_W  = 1;
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [LEN_W-1:0]    len_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic        [VALUE_W-1:0]  value_t;
    typedef logic        [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_WINDOW_LENGTH = 1'b0;
    localparam cfg_addr_t REG_MODE          = 1'b1;

    localparam logic MODE_RMS  = 1'b0;
    localparam logic MODE_MEAN = 1'b1;

    localparam len_t WINDOW_LENGTH_RESET = 11'd1024;

    // one word handed from the front end to the arithmetic back end
    typedef struct packed {
        sum_t sum;
        logic ready;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_SUM
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_SQRT,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/mwrm_ram.sv =====
// ----------------------------------------------------------------------------
// mwrm_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mwrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/mwrm_front.sv =====
// ----------------------------------------------------------------------------
// mwrm_front
// Accepts samples, maintains the sample ring and the running sum, and pushes
// one job per sample into the queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mwrm_front #(
    parameter int WINDOW_MAX = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            clear,
    input  wire mwrm_pkg::len_t  len,
    input  wire logic            mode,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire mwrm_pkg::sample_t in_sample,
    input  wire logic            q_full,
    output logic                 push,
    output mwrm_pkg::job_t       push_job
);
    import mwrm_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int CMP_W = (PTR_W + 1 > LEN_W) ? PTR_W + 1 : LEN_W;

    front_state_t state_reg, state_next;
    sample_t      sample_reg, sample_next;
    sum_t         old_term_reg, old_term_next;
    sum_t         new_term_reg, new_term_next;
    sum_t         sum_reg, sum_next;
    logic [PTR_W-1:0] oldest_reg, oldest_next;
    len_t         fill_reg, fill_next;

    logic                        full;
    logic                        ram_we;
    logic                        ram_re;
    logic [PTR_W-1:0]            ram_waddr;
    logic [SAMPLE_W-1:0]         ram_rdata;
    sample_t                     old_sample;
    logic signed [2*SAMPLE_W-1:0] new_sq;
    logic signed [2*SAMPLE_W-1:0] old_sq;
    logic [CMP_W-1:0]            oldest_inc;

    mwrm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (oldest_reg),
        .rdata (ram_rdata)
    );

    assign full       = (fill_reg >= len);
    assign old_sample = ram_rdata;
    assign new_sq     = sample_reg * sample_reg;
    assign old_sq     = old_sample * old_sample;
    assign oldest_inc = CMP_W'(oldest_reg) + CMP_W'(1);
    assign in_ready   = (state_reg == F_IDLE);
    assign ram_re     = in_valid && in_ready;
    // the oldest position stays at zero while the window fills
    assign ram_waddr  = full ? oldest_reg : PTR_W'(fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            sum_reg    <= '0;
            oldest_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            oldest_reg <= oldest_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        old_term_reg <= old_term_next;
        new_term_reg <= new_term_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        old_term_next = old_term_reg;
        new_term_next = new_term_reg;
        sum_next      = sum_reg;
        oldest_next   = oldest_reg;
        fill_next     = fill_reg;
        ram_we        = 1'b0;
        push          = 1'b0;
        push_job.sum  = sum_reg + new_term_reg - old_term_reg;
        push_job.ready = full;

        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = in_sample;
                    state_next  = F_READ;
                end
            end
            F_READ:
            begin
                // ring data for the oldest entry is valid now
                ram_we        = 1'b1;
                new_term_next = (mode == MODE_MEAN) ? SUM_W'(sample_reg) : SUM_W'(new_sq);
                if (!full)
                begin
                    old_term_next = '0;
                end
                else
                begin
                    old_term_next = (mode == MODE_MEAN) ? SUM_W'(old_sample)
                                                        : SUM_W'(old_sq);
                end
                state_next = F_SUM;
            end
            F_SUM:
            begin
                // hold until the queue has room
                if (!q_full)
                begin
                    push     = 1'b1;
                    sum_next = push_job.sum;
                    if (full)
                    begin
                        oldest_next = (oldest_inc == CMP_W'(len)) ? '0
                                                                  : oldest_inc[PTR_W-1:0];
                    end
                    else
                    begin
                        fill_next = fill_reg + len_t'(1);
                    end
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase

        if (clear)
        begin
            sum_next    = '0;
            oldest_next = '0;
            fill_next   = '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mwrm_fifo.sv =====
// ----------------------------------------------------------------------------
// mwrm_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mwrm_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mwrm_pkg::job_t push_job,
    input  wire logic           pop,
    output mwrm_pkg::job_t      pop_job,
    output logic                empty,
    output logic                full
);
    import mwrm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             ent_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_job = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mwrm_back.sv =====
// ----------------------------------------------------------------------------
// mwrm_back
// Divides the running sum by the window length one bit a cycle, takes the
// integer square root two bits a cycle in rms mode, and holds the result in
// an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mwrm_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mwrm_pkg::len_t  len,
    input  wire logic            mode,
    input  wire logic            job_valid,
    input  wire mwrm_pkg::job_t  job,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output mwrm_pkg::value_t     out_value,
    output logic                 out_ready_res
);
    import mwrm_pkg::*;

    back_state_t            state_reg, state_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic                   neg_reg, neg_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ROOT_IN_W-1:0]   sq_x_reg, sq_x_next;
    logic [ROOT_W+1:0]      sq_rem_reg, sq_rem_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    value_t                 res_reg, res_next;
    logic                   res_ok_reg, res_ok_next;
    logic                   out_valid_reg, out_valid_next;
    value_t                 out_value_reg, out_value_next;
    logic                   out_ok_reg, out_ok_next;

    logic [LEN_W:0]         div_sh;
    logic                   div_bit;
    logic [DIV_W-1:0]       quo_step;
    logic [ROOT_W+1:0]      sq_sh;
    logic [ROOT_W+1:0]      sq_trial;
    logic                   sq_bit;
    logic [ROOT_W-1:0]      root_step;
    logic [SUM_W-1:0]       sum_mag;
    value_t                 quo_low;

    assign div_sh    = {rem_reg, quo_reg[DIV_W-1]};
    assign div_bit   = (div_sh >= {1'b0, len});
    assign quo_step  = {quo_reg[DIV_W-2:0], div_bit};
    assign quo_low   = quo_step[VALUE_W-1:0];
    assign sq_sh     = {sq_rem_reg[ROOT_W-1:0], sq_x_reg[ROOT_IN_W-1 -: 2]};
    assign sq_trial  = {root_reg, 2'b01};
    assign sq_bit    = (sq_sh >= sq_trial);
    assign root_step = {root_reg[ROOT_W-2:0], sq_bit};
    assign sum_mag   = job.sum[SUM_W-1] ? -job.sum : job.sum;

    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign out_ready_res = out_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        sq_x_reg      <= sq_x_next;
        sq_rem_reg    <= sq_rem_next;
        root_reg      <= root_next;
        res_reg       <= res_next;
        res_ok_reg    <= res_ok_next;
        out_value_reg <= out_value_next;
        out_ok_reg    <= out_ok_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        sq_x_next      = sq_x_reg;
        sq_rem_next    = sq_rem_reg;
        root_next      = root_reg;
        res_next       = res_reg;
        res_ok_next    = res_ok_reg;
        out_value_next = out_value_reg;
        out_ok_next    = out_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    pop = 1'b1;
                    if (job.ready)
                    begin
                        neg_next    = job.sum[SUM_W-1];
                        quo_next    = sum_mag[DIV_W-1:0];
                        rem_next    = '0;
                        cnt_next    = DIV_CNT_W'(DIV_W - 1);
                        res_ok_next = 1'b1;
                        state_next  = B_DIV;
                    end
                    else
                    begin
                        res_next    = '0;
                        res_ok_next = 1'b0;
                        state_next  = B_OUT;
                    end
                end
            end
            B_DIV:
            begin
                rem_next = div_bit ? LEN_W'(div_sh - {1'b0, len}) : div_sh[LEN_W-1:0];
                quo_next = quo_step;
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (mode == MODE_MEAN)
                    begin
                        // truncate toward zero: divide the magnitude, restore the sign
                        res_next   = neg_reg ? -quo_low : quo_low;
                        state_next = B_OUT;
                    end
                    else
                    begin
                        sq_x_next   = neg_reg ? '0 : quo_step[ROOT_IN_W-1:0];
                        sq_rem_next = '0;
                        root_next   = '0;
                        cnt_next    = DIV_CNT_W'(ROOT_W - 1);
                        state_next  = B_SQRT;
                    end
                end
            end
            B_SQRT:
            begin
                sq_rem_next = sq_bit ? sq_sh - sq_trial : sq_sh;
                sq_x_next   = {sq_x_reg[ROOT_IN_W-3:0], 2'b00};
                root_next   = root_step;
                cnt_next    = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    res_next   = VALUE_W'(root_step);
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                // load when the output word is free or being taken
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_ok_next    = res_ok_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/moving_window_rms_mean.sv =====
// ----------------------------------------------------------------------------
// moving_window_rms_mean
// Sliding-window rms or mean of a signed sample stream.
// A sample passes the front end, the queue pop, the serial divider, the
// square root in rms mode and the output load; while the window fills the
// divider and square root are skipped. One divider / square root unit is
// shared by all samples; the front end takes the next sample while it works,
// unless the queue is full.
// Reset clears the window, sets window length 1024 and rms mode; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_window_rms_mean #(
    parameter int WINDOW_MAX = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [mwrm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [15:0] sample
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [mwrm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // [16:0] value
    output logic [mwrm_pkg::OUT_TUSER_W-1:0]         m_axis_tuser,  // [0] ready_res
    input  wire logic                                cfg_we,
    input  wire mwrm_pkg::cfg_addr_t                 cfg_addr,
    input  wire logic [mwrm_pkg::LEN_W-1:0]          cfg_data
);
    import mwrm_pkg::*;

    len_t   wl_reg, wl_next;
    logic   mode_reg, mode_next;
    len_t   len;
    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    job_t   push_job;
    job_t   pop_job;
    value_t value;
    logic   ready_res;

    always_comb
    begin
        wl_next   = wl_reg;
        mode_next = mode_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_WINDOW_LENGTH: wl_next   = cfg_data;
                REG_MODE:          mode_next = cfg_data[0];
                default:           wl_next   = wl_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg   <= WINDOW_LENGTH_RESET;
            mode_reg <= MODE_RMS;
        end
        else
        begin
            wl_reg   <= wl_next;
            mode_reg <= mode_next;
        end
    end

    // clamp the window length to 1 .. WINDOW_MAX
    always_comb
    begin
        if (wl_reg == '0)
        begin
            len = len_t'(1);
        end
        else if (32'(wl_reg) > WINDOW_MAX)
        begin
            len = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len = wl_reg;
        end
    end

    mwrm_front #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_we),
        .len       (len),
        .mode      (mode_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata[SAMPLE_W-1:0]),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    mwrm_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    mwrm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .len           (len),
        .mode          (mode_reg),
        .job_valid     (!q_empty),
        .job           (pop_job),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_value     (value),
        .out_ready_res (ready_res)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - VALUE_W){1'b0}}, value};
    assign m_axis_tuser = ready_res;

endmodule

`default_nettype wire

// ===== rtl/mwrm_checker.sv =====
// ----------------------------------------------------------------------------
// mwrm_checker
// Port-level checks for the moving-window rms / mean block.
// ----------------------------------------------------------------------------
`default_nettype none

module mwrm_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    input  wire logic                                s_axis_tready,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [mwrm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic [mwrm_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
    import mwrm_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // a window that is not yet full reports zero
    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("nonzero value without ready flag");

    // padding above the value stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:VALUE_W] == '0)
        else $error("padding bits set in result word");

    // the front end works on one sample at a time
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample accepted while front end busy");

endmodule

bind moving_window_rms_mean mwrm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
